// ===== sv/fqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg
// shared types and constants of the fifo queue with delete by value
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int ITEM_W = 32;
  localparam int CMD_W  = 2;
  localparam int OCC_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_SHIFT,
    ST_SHIFT_WR
  } fqd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push_tail;  // write request value at tail, count up
    logic pop_head;   // advance head, count down
    logic count_dec;  // count down after a delete
    logic load_key;   // latch search key, clear position
    logic rd_head;    // read entry at head
    logic rd_next;    // read entry at position plus one
    logic pos_inc;    // advance position
    logic wr_shift;   // write read data at position
    logic out_load;   // load result register
    logic out_ok;     // ok bit of the result
    logic out_data;   // result carries the read data
  } fqd_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic last;
    logic out_busy;
  } fqd_stat_t;

endpackage

// ===== sv/fqd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_req_if / fqd_rsp_if
// valid/ready channels for queue requests and queue results
// ----------------------------------------------------------------------------
interface fqd_req_if import fqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface fqd_rsp_if import fqd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ITEM_W-1:0] item_out;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output ok, output item_out, output occupancy,
                  input ready);
  modport sink   (input valid, input ok, input item_out, input occupancy,
                  output ready);
endinterface

// ===== sv/fqd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_ctrl
// sequencer for enqueue, dequeue and delete scan/shift
// ----------------------------------------------------------------------------
module fqd_ctrl import fqd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] req_cmd,
  output logic             req_ready,
  input  fqd_stat_t        stat,
  output fqd_ctl_t         ctl
);

  fqd_state_t state, state_next;
  logic       fire;

  assign req_ready = (state == ST_IDLE) && !stat.out_busy;
  assign fire      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          case (req_cmd)
            CMD_DEQ: if (!stat.empty) state_next = ST_DEQ;
            CMD_DEL: if (!stat.empty) state_next = ST_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEQ: state_next = ST_IDLE;
      ST_SCAN: begin
        if (stat.match) begin
          state_next = ST_SHIFT;
        end else if (stat.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT: state_next = stat.last ? ST_IDLE : ST_SHIFT_WR;
      ST_SHIFT_WR: state_next = ST_SHIFT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          case (req_cmd)
            CMD_ENQ: begin
              ctl.push_tail = !stat.full;
              ctl.out_ok    = !stat.full;
              ctl.out_load  = 1'b1;
            end
            CMD_DEQ: begin
              ctl.rd_head  = !stat.empty;
              ctl.out_load = stat.empty;
            end
            CMD_DEL: begin
              ctl.rd_head  = !stat.empty;
              ctl.load_key = 1'b1;
              ctl.out_load = stat.empty;
            end
            default: ctl.out_load = 1'b1;
          endcase
        end
      end
      ST_DEQ: begin
        ctl.pop_head = 1'b1;
        ctl.out_load = 1'b1;
        ctl.out_ok   = 1'b1;
        ctl.out_data = 1'b1;
      end
      ST_SCAN: begin
        if (!stat.match) begin
          if (stat.last) begin
            ctl.out_load = 1'b1;
          end else begin
            ctl.rd_next = 1'b1;
            ctl.pos_inc = 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        if (stat.last) begin
          ctl.count_dec = 1'b1;
          ctl.out_load  = 1'b1;
          ctl.out_ok    = 1'b1;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.pos_inc  = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== sv/fqd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_datapath
// circular entry memory, head/count/position registers, result register
// ----------------------------------------------------------------------------
module fqd_datapath import fqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ITEM_W-1:0] item_value,
  input  fqd_ctl_t          ctl,
  output fqd_stat_t         stat,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output logic              ok,
  output logic [ITEM_W-1:0] item_out,
  output logic [OCC_W-1:0]  occupancy
);

  localparam int AW  = $clog2(DEPTH);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CW1 = CW + 1;
  localparam logic [AW1-1:0] DEPTH_A  = AW1'(DEPTH);
  localparam logic [CW-1:0]  DEPTH_C  = CW'(DEPTH);
  localparam logic [AW-1:0]  HEAD_MAX = AW'(DEPTH - 1);

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rd_data;
  logic [ITEM_W-1:0] key;
  logic [AW-1:0]     head;
  logic [AW-1:0]     pos;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic [ITEM_W-1:0] wr_data;
  logic [OCC_W+CW-1:0] occ_ext;

  // logical position to memory address, wraps once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [AW-1:0] p);
    logic [AW1-1:0] s;
    s = {1'b0, h} + {1'b0, p};
    if (s >= DEPTH_A) s = s - DEPTH_A;
    return s[AW-1:0];
  endfunction

  always_comb begin
    count_next = count;
    if (ctl.push_tail) count_next = count + CW'(1);
    else if (ctl.pop_head || ctl.count_dec) count_next = count - CW'(1);
  end

  assign rd_en   = ctl.rd_head || ctl.rd_next;
  assign rd_addr = ctl.rd_head ? head : phys(head, pos + AW'(1));
  assign wr_en   = ctl.push_tail || ctl.wr_shift;
  assign wr_addr = ctl.push_tail ? phys(head, count[AW-1:0]) : phys(head, pos);
  assign wr_data = ctl.push_tail ? item_value : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      pos   <= '0;
    end else begin
      count <= count_next;
      if (ctl.pop_head) head <= (head == HEAD_MAX) ? '0 : head + AW'(1);
      if (ctl.load_key) pos <= '0;
      else if (ctl.pos_inc) pos <= pos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_key) key <= item_value;
  end

  // result register
  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      ok        <= ctl.out_ok;
      item_out  <= ctl.out_data ? rd_data : '0;
      occupancy <= occ_ext[OCC_W-1:0];
    end
  end

  assign stat.full     = (count == DEPTH_C);
  assign stat.empty    = (count == '0);
  assign stat.match    = (rd_data == key);
  assign stat.last     = (CW1'(pos) + CW1'(1)) >= CW1'(count);
  assign stat.out_busy = rsp_valid && !rsp_ready;

endmodule

// ===== sv/fifo_queue_with_delete_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_core
// ordered queue with enqueue, dequeue and delete of the first matching value
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH 32-bit values in a circular dual-port-style
// memory (one write and one registered read per cycle) addressed from a head
// pointer. Each request gives exactly one result with ok, item_out and the
// occupancy after the operation. An enqueue is answered from the idle state,
// so enqueues run back to back while each result is taken as it appears. A
// dequeue reads the head, then pops it and returns it. A delete scans from
// the head one entry a cycle, through all held entries when nothing matches;
// the entries behind the first match are moved up by one, a read and a write
// each. The one read port of the entry memory paces scan and shift. An
// enqueue on a full queue, a dequeue or delete on an empty queue and the
// unused command code are answered from the idle state with ok low. A new
// request is taken once the sequencer is idle and the result register is
// empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_core import fqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  fqd_req_if.sink  req,
  fqd_rsp_if.source rsp
);

  // command and status between sequencer and datapath
  fqd_ctl_t  ctl;
  fqd_stat_t stat;

  // sequencer: decodes the request and steps through scan and shift
  fqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // datapath: entry memory, pointers and the result register
  fqd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .item_value (req.item_value),
    .ctl        (ctl),
    .stat       (stat),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .ok         (rsp.ok),
    .item_out   (rsp.item_out),
    .occupancy  (rsp.occupancy)
  );

endmodule

// ===== sv/fqd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_checker
// port-level checks of the queue core, bound to the top level
// ----------------------------------------------------------------------------
module fqd_checker import fqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              ok,
  input logic [ITEM_W-1:0] item_out,
  input logic [OCC_W-1:0]  occupancy
);

  // requests taken whose result is not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd1)
    else $error("more than one request in flight");

  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending == 2'd1)
    else $error("result without a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !ok |-> item_out == '0)
    else $error("failed result carries data");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> int'(occupancy) <= DEPTH)
    else $error("occupancy above depth");

endmodule

bind fifo_queue_with_delete_core fqd_checker #(
  .DEPTH (DEPTH)
) u_fqd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .ok        (rsp.ok),
  .item_out  (rsp.item_out),
  .occupancy (rsp.occupancy)
);

// ===== tb/sv/fifo_queue_with_delete_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_core_tb
// self-checking bench for the ordered queue with delete by value
// ----------------------------------------------------------------------------
// Requests go in on the request channel and results come back on the result
// channel. A scoreboard object keeps its own copy of the queue contents,
// works out the result of each request when it is taken, and compares each
// result with the oldest one it is waiting for. A short directed part covers
// the empty, full, no-match and unused-command cases and the value extremes.
// A long random part then switches at random between filling, draining and
// mixed phases, and most deletes aim at values that are actually held. Both channels idle in
// random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_core_tb;
  import fqd_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS   = 900;
  localparam int CALM_ITEMS   = 150;
  localparam int SETTLE_CYCLES = 2 * QDEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // command code the block must refuse with ok low
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } load_mode_t;

  typedef struct packed {
    logic              ok;
    logic [ITEM_W-1:0] data;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the queue plus the results still to come
  // --------------------------------------------------------------------------
  class queue_scoreboard;
    logic [ITEM_W-1:0] held[$];
    queue_result_t     awaited[$];
    int unsigned       depth;
    int unsigned       failures;

    function new(int unsigned depth_i);
      depth    = depth_i;
      failures = 0;
    endfunction

    function int unsigned held_count();
      return held.size();
    endfunction

    function logic [ITEM_W-1:0] entry_at(int unsigned idx);
      return held[idx];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // apply one taken request to the mirror and queue up its result
    function void note_request(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] value);
      queue_result_t r;
      int            pos;
      r   = '0;
      pos = -1;
      case (cmd)
        CMD_ENQ: begin
          if (held.size() < depth) begin
            held.push_back(value);
            r.ok = 1'b1;
          end
        end
        CMD_DEQ: begin
          if (held.size() > 0) begin
            r.data = held.pop_front();
            r.ok   = 1'b1;
          end
        end
        CMD_DEL: begin
          // first match counted from the head
          foreach (held[i])
            if (pos < 0 && held[i] == value) pos = i;
          if (pos >= 0) begin
            held.delete(pos);
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.occ = OCC_W'(held.size());
      awaited.push_back(r);
    endfunction

    function void check_result(logic ok, logic [ITEM_W-1:0] data,
                               logic [OCC_W-1:0] occ);
      queue_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] unexpected result: ok=%b item_out=%h occupancy=%0d",
                   $realtime, ok, data, occ);
        return;
      end
      want = awaited.pop_front();
      if (ok !== want.ok || data !== want.data || occ !== want.occ) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] mismatch: ok %b/%b item_out %h/%h occupancy %0d/%0d (exp/act)",
                   $realtime, want.ok, ok, want.data, data, want.occ, occ);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  fqd_req_if req_if ();
  fqd_rsp_if rsp_if ();

  fifo_queue_with_delete_core #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  queue_scoreboard sb;
  bit              calm = 1'b0;  // no idling on either side once set
  int unsigned     cycles = 0;

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // drive one request, maybe after an idle burst, and hold it until taken
  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [ITEM_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.item_value <= value;
    do @(posedge clk); while (!req_if.ready);
    // taken at this edge; its result cannot come back before the next one
    sb.note_request(cmd, value);
  endtask

  // mostly small values so that duplicates and matches are common
  function automatic logic [ITEM_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return ITEM_W'($urandom_range(0, 7));
    if (sel < 50) return '0;
    if (sel < 55) return '1;
    return $urandom;
  endfunction

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] value;
    load_mode_t        mode;
    int unsigned       occ;
    int unsigned       sel;
    int unsigned       enq_pct;

    sb = new(QDEPTH);
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_ENQ;
    req_if.item_value <= '0;
    rsp_if.ready      <= 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: everything on an empty queue fails
    send_request(CMD_DEQ, 32'h0000_0000);
    send_request(CMD_DEL, 32'h0000_0000);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF);

    // directed: fill to the top with extremes and a duplicate pair
    send_request(CMD_ENQ, 32'h0000_0000);
    send_request(CMD_ENQ, 32'hFFFF_FFFF);
    send_request(CMD_ENQ, 32'h5555_5555);
    send_request(CMD_ENQ, 32'hAAAA_AAAA);
    send_request(CMD_ENQ, 32'h0000_1234);
    send_request(CMD_ENQ, 32'h8000_0001);
    send_request(CMD_ENQ, 32'h0000_1234);
    for (int k = 0; k < QDEPTH - 7; k++)
      send_request(CMD_ENQ, 32'h0000_0100 + k);

    // directed: full queue drops the value, unused code does nothing
    send_request(CMD_ENQ, 32'hDEAD_BEEF);
    send_request(CMD_UNUSED, 32'h0000_0000);

    // directed: delete the tail, the first of a duplicate pair, an absent value
    send_request(CMD_DEL, 32'h0000_0100 + QDEPTH - 8);
    send_request(CMD_DEL, 32'h0000_1234);
    send_request(CMD_DEL, 32'hDEAD_BEEF);
    send_request(CMD_DEQ, 32'h0000_0000);

    // random: phases push the fill level up to full and down to empty
    mode = MODE_MIX;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0) mode = load_mode_t'($urandom_range(0, 2));
      if (n >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      occ = sb.held_count();
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        cmd   = CMD_UNUSED;
        value = $urandom;
      end else if (sel < 23) begin
        cmd = CMD_DEL;
        // most deletes hit a held value somewhere between head and tail
        if (occ > 0 && $urandom_range(0, 4) != 0)
          value = sb.entry_at($urandom_range(0, occ - 1));
        else
          value = pick_value();
      end else begin
        case (mode)
          MODE_FILL:  enq_pct = 75;
          MODE_DRAIN: enq_pct = 30;
          default:    enq_pct = 55;
        endcase
        if ($urandom_range(0, 99) < enq_pct) begin
          cmd   = CMD_ENQ;
          value = pick_value();
        end else begin
          cmd   = CMD_DEQ;
          value = $urandom;
        end
      end
      send_request(cmd, value);
    end
    req_if.valid <= 1'b0;

    // drain the outstanding results, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random back-pressure bursts, check every taken result
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.ok, rsp_if.item_out, rsp_if.occupancy);
      if (stall > 0)
        stall--;
      else if (!calm && $urandom_range(0, 7) == 0)
        stall = $urandom_range(1, 14);
      rsp_if.ready <= (stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fqd_pkg.sv
sv/fqd_ifs.sv
sv/fqd_ctrl.sv
sv/fqd_datapath.sv
sv/fifo_queue_with_delete_core.sv
sv/fqd_checker.sv
tb/sv/fifo_queue_with_delete_core_tb.sv
